// ===== rtl/gar_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gar_pkg
// Shared types and constants of the line-numbered command handshake
// controller.
// ----------------------------------------------------------------------------
package gar_pkg;

  localparam int MaxAttemptsDefault = 8;
  localparam int AttemptW           = 4;
  localparam int LineW              = 31;
  localparam int QuietW             = 17;
  localparam int TimeoutW           = 16;
  localparam int CfgIdxW            = 4;
  localparam int CfgDataW           = 16;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd5000;

  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT  = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_OK_AFTER = 4'd1;

  localparam logic [7:0] CH_LO_O = 8'h6F;
  localparam logic [7:0] CH_LO_K = 8'h6B;
  localparam logic [7:0] CH_UP_R = 8'h52;
  localparam logic [7:0] CH_LO_E = 8'h65;
  localparam logic [7:0] CH_LO_S = 8'h73;
  localparam logic [7:0] CH_LO_N = 8'h6E;
  localparam logic [7:0] CH_LO_D = 8'h64;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_STATUS = 2'd1,
    OP_BYTE   = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ERROR   = 2'd1,
    ST_BUSY    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    EV_SEND      = 4'd0,
    EV_RESET     = 4'd1,
    EV_SUCCESS   = 4'd2,
    EV_FAILED    = 4'd3,
    EV_GAVEUP    = 4'd4,
    EV_INVALID   = 4'd5,
    EV_TXERR     = 4'd6,
    EV_TXBUSY    = 4'd7,
    EV_TXTIMEOUT = 4'd8,
    EV_RXTIMEOUT = 4'd9
  } event_e;

  typedef struct packed {
    op_e         op;
    logic        machine_ok;
    logic        cmd_empty;
    status_e     status;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [TimeoutW-1:0] timeout;
    logic                ok_after_resend;
  } cfg_t;

  typedef struct packed {
    event_e             kind;
    logic [LineW-1:0]   line;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/gar_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gar_if
// Channel interfaces: input items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface gar_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] target_machine;
  logic       command_empty;
  logic [1:0] uart_send_status;
  logic [7:0] rx_byte;

  modport source (output valid, opcode, target_machine, command_empty,
                  uart_send_status, rx_byte, input ready);
  modport sink (input valid, opcode, target_machine, command_empty,
                uart_send_status, rx_byte, output ready);
endinterface

interface gar_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [30:0] line_number;
  logic        last_of_run;

  modport source (output valid, event_kind, line_number, last_of_run, input ready);
  modport sink (input valid, event_kind, line_number, last_of_run, output ready);
endinterface

interface gar_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/gar_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gar_front
// Accepts input items and classifies them into compact queue entries.
// ----------------------------------------------------------------------------
module gar_front
  import gar_pkg::*;
(
  gar_in_if.sink in_i,
  input  wire    full_i,
  output logic   push_o,
  output item_t  item_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    item_o.op         = op_e'(in_i.opcode);
    item_o.machine_ok = (in_i.target_machine == 8'd1);
    item_o.cmd_empty  = in_i.command_empty;
    item_o.status     = status_e'(in_i.uart_send_status);
    item_o.rx_byte    = in_i.rx_byte;
  end

endmodule
`default_nettype wire

// ===== rtl/gar_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gar_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module gar_queue
  import gar_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  item_t item_i,
  output logic  full_o,
  input  wire   pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gar_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gar_back
// Executes queued items: handshake control, reply matching, retry policy,
// and a two-result output buffer.
// ----------------------------------------------------------------------------
module gar_back
  import gar_pkg::*;
#(
  parameter int MAX_ATTEMPTS = MaxAttemptsDefault
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  input  cfg_t   cfg_i,
  input  wire    q_valid_i,
  input  item_t  q_item_i,
  output logic   pop_o,
  gar_out_if.source out_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_STATUS = 3'b010,
    PH_REPLY  = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    RP_SEND   = 3'b001,
    RP_RESEND = 3'b010,
    RP_RESET  = 3'b100
  } retry_e;

  typedef enum logic [8:0] {
    M_OR = 9'b000000001,
    M_K1 = 9'b000000010,
    M_E1 = 9'b000000100,
    M_S  = 9'b000001000,
    M_E2 = 9'b000010000,
    M_N  = 9'b000100000,
    M_D  = 9'b001000000,
    M_O  = 9'b010000000,
    M_K2 = 9'b100000000
  } match_e;

  phase_e              phase_q, phase_d;
  retry_e              retry_q, retry_d;
  match_e              match_q, match_d;
  logic [AttemptW-1:0] att_q, att_d;
  logic [LineW-1:0]    line_q, line_d;
  logic [QuietW-1:0]   quiet_q, quiet_d;

  res_t                res_q [2];
  res_t                res_d [2];
  logic [1:0]          cnt_q, cnt_d;

  logic                take;
  logic                out_fire;
  logic [1:0]          n;
  event_e              k0, k1;
  logic [LineW-1:0]    l0, l1;
  logic                do_att;
  logic [AttemptW-1:0] att_base;
  logic                hit_ok, hit_resend;
  logic [QuietW-1:0]   quiet_inc;
  event_e              att_kind;
  logic [LineW-1:0]    att_line;

  assign out_fire = out_o.valid && out_o.ready;
  assign take     = q_valid_i && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready));
  assign pop_o    = take;

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.event_kind  = res_q[0].kind;
  assign out_o.line_number = res_q[0].line;
  assign out_o.last_of_run = res_q[0].last;

  always_comb begin
    phase_d    = phase_q;
    retry_d    = retry_q;
    match_d    = match_q;
    att_d      = att_q;
    line_d     = line_q;
    quiet_d    = quiet_q;
    n          = 2'd0;
    k0         = EV_SEND;
    k1         = EV_SEND;
    l0         = '0;
    l1         = '0;
    do_att     = 1'b0;
    att_base   = att_q;
    hit_ok     = 1'b0;
    hit_resend = 1'b0;
    att_kind   = EV_SEND;
    att_line   = '0;
    quiet_inc  = (quiet_q == {QuietW{1'b1}}) ? quiet_q : quiet_q + QuietW'(1);

    if (take) begin
      case (q_item_i.op)
        OP_START: begin
          if (phase_q == PH_IDLE) begin
            if (!q_item_i.machine_ok) begin
              k0 = EV_INVALID;
              n  = 2'd1;
            end else if (q_item_i.cmd_empty) begin
              k0 = EV_FAILED;
              n  = 2'd1;
            end else begin
              retry_d  = RP_SEND;
              att_base = '0;
              do_att   = 1'b1;
            end
          end
        end
        OP_STATUS: begin
          if (phase_q == PH_STATUS) begin
            case (q_item_i.status)
              ST_OK: begin
                phase_d = PH_REPLY;
                match_d = M_OR;
                quiet_d = '0;
              end
              ST_ERROR: k0 = EV_TXERR;
              ST_BUSY: k0 = EV_TXBUSY;
              ST_TIMEOUT: k0 = EV_TXTIMEOUT;
              default: k0 = EV_TXERR;
            endcase
            if (q_item_i.status != ST_OK) begin
              k1      = EV_FAILED;
              n       = 2'd2;
              phase_d = PH_IDLE;
            end
          end
        end
        OP_BYTE: begin
          if (phase_q == PH_REPLY) begin
            quiet_d = '0;
            case (match_q)
              M_OR: begin
                if (q_item_i.rx_byte == CH_LO_O) begin
                  match_d = M_K1;
                end else if (q_item_i.rx_byte == CH_UP_R) begin
                  match_d = M_E1;
                end
              end
              M_K1: begin
                match_d = M_OR;
                hit_ok  = (q_item_i.rx_byte == CH_LO_K);
              end
              M_E1: match_d = (q_item_i.rx_byte == CH_LO_E) ? M_S : M_OR;
              M_S: match_d = (q_item_i.rx_byte == CH_LO_S) ? M_E2 : M_OR;
              M_E2: match_d = (q_item_i.rx_byte == CH_LO_E) ? M_N : M_OR;
              M_N: match_d = (q_item_i.rx_byte == CH_LO_N) ? M_D : M_OR;
              M_D: begin
                if (q_item_i.rx_byte == CH_LO_D) begin
                  if (cfg_i.ok_after_resend) begin
                    match_d = M_O;
                  end else begin
                    hit_resend = 1'b1;
                  end
                end else begin
                  match_d = M_OR;
                end
              end
              M_O: begin
                if (q_item_i.rx_byte == CH_LO_O) begin
                  match_d = M_K2;
                end
              end
              M_K2: begin
                if (q_item_i.rx_byte == CH_LO_K) begin
                  hit_resend = 1'b1;
                end else begin
                  match_d = M_O;
                end
              end
              default: match_d = M_OR;
            endcase
            if (hit_ok) begin
              line_d = line_q + LineW'(1);
              if (retry_q == RP_RESET) begin
                retry_d = RP_SEND;
                do_att  = 1'b1;
              end else begin
                phase_d = PH_IDLE;
                k0      = EV_SUCCESS;
                n       = 2'd1;
              end
            end else if (hit_resend) begin
              retry_d = (retry_q == RP_SEND) ? RP_RESEND : RP_RESET;
              do_att  = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (phase_q == PH_REPLY) begin
            quiet_d = quiet_inc;
            if (quiet_inc > {1'b0, cfg_i.timeout}) begin
              k0      = EV_RXTIMEOUT;
              n       = 2'd1;
              retry_d = (retry_q == RP_SEND) ? RP_RESEND : RP_RESET;
              do_att  = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (do_att) begin
        if (att_base >= AttemptW'(MAX_ATTEMPTS)) begin
          phase_d  = PH_IDLE;
          att_kind = EV_GAVEUP;
        end else begin
          att_d   = att_base + AttemptW'(1);
          phase_d = PH_STATUS;
          if (retry_d == RP_RESET) begin
            line_d   = '0;
            att_kind = EV_RESET;
          end else begin
            att_kind = EV_SEND;
            att_line = line_d;
          end
        end
        if (n == 2'd0) begin
          k0 = att_kind;
          l0 = att_line;
        end else begin
          k1 = att_kind;
          l1 = att_line;
        end
        n = n + 2'd1;
      end
    end
  end

  always_comb begin
    res_d[0] = res_q[0];
    res_d[1] = res_q[1];
    cnt_d    = cnt_q;
    if (take) begin
      res_d[0].kind = k0;
      res_d[0].line = l0;
      res_d[0].last = (n == 2'd1);
      res_d[1].kind = k1;
      res_d[1].line = l1;
      res_d[1].last = 1'b1;
      cnt_d         = n;
    end else if (out_fire) begin
      res_d[0] = res_q[1];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      retry_q <= RP_SEND;
      match_q <= M_OR;
      att_q   <= '0;
      line_q  <= '0;
      quiet_q <= '0;
      cnt_q   <= 2'd0;
    end else begin
      phase_q <= phase_d;
      retry_q <= retry_d;
      match_q <= match_d;
      att_q   <= att_d;
      line_q  <= line_d;
      quiet_q <= quiet_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q[0] <= res_d[0];
    res_q[1] <= res_d[1];
  end

endmodule
`default_nettype wire

// ===== rtl/gcode_ack_resend_retry_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcode_ack_resend_retry_controller
// Host side of a line-numbered command handshake with ok/Resend matching
// and a bounded send, resend, line-reset retry policy.
// ----------------------------------------------------------------------------
// The block takes one input item per cycle into a two-entry queue while the
// queue is not full; the back end executes one queued item per cycle while
// its output buffer is empty or holds one result that is being taken, and
// loads its zero, one or two result items into a two-slot output buffer,
// which drains one result item per cycle while the output is ready. After an
// item with two results, the next item waits. There is no clearing pass after reset.
module gcode_ack_resend_retry_controller
  import gar_pkg::*;
#(
  parameter int MAX_ATTEMPTS = MaxAttemptsDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  gar_in_if.sink       in_i,
  gar_out_if.source    out_o,
  gar_cfg_if.sink      cfg_i
);

  cfg_t  cfg_q;
  logic  full;
  logic  push;
  item_t front_item;
  logic  q_valid;
  item_t q_item;
  logic  pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout         <= TimeoutReset;
      cfg_q.ok_after_resend <= 1'b1;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_TIMEOUT) begin
        cfg_q.timeout <= cfg_i.data[TimeoutW-1:0];
      end else if (cfg_i.index == CFG_OK_AFTER) begin
        cfg_q.ok_after_resend <= cfg_i.data[0];
      end
    end
  end

  gar_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  gar_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  gar_back #(
    .MAX_ATTEMPTS (MAX_ATTEMPTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the command handshake controller against a predictor of the ack,
// resend and retry behavior. A table of directed items comes first, then
// random protocol runs under several register settings, with random idling
// on both channels and one long hold-off of the result channel.
// ----------------------------------------------------------------------------
module testbench;
  import gar_pkg::*;

  localparam int          MaxTries      = MaxAttemptsDefault;
  localparam int          CycleLimit    = 1_000_000;
  localparam int          SettleCycles  = 16;
  localparam int          HoldCycles    = 150;
  localparam logic [7:0]  TargetMachine = 8'd1;

  typedef enum logic [1:0] {CTL_IDLE, CTL_WAIT_STATUS, CTL_WAIT_REPLY} ctl_e;
  typedef enum logic [1:0] {TRY_SEND, TRY_RESEND, TRY_LINE_RESET} try_e;
  typedef enum logic [3:0] {
    SCAN_O_OR_R, SCAN_K, SCAN_E1, SCAN_S, SCAN_E2, SCAN_N, SCAN_D, SCAN_O, SCAN_K2
  } scan_e;
  typedef enum logic [1:0] {HEARD_NONE, HEARD_OK, HEARD_RESEND} heard_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] machine;
    logic       empty;
    status_e    status;
    logic [7:0] rx;
  } cmd_t;

  typedef struct {
    cmd_t        cmd;
    int          reps;
    int          n_typed;
    event_e      k0;
    logic [30:0] l0;
    event_e      k1;
  } plan_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  gar_in_if  in_ch ();
  gar_out_if out_ch ();
  gar_cfg_if cfg_ch ();

  gcode_ack_resend_retry_controller u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Predicted state of the controller and its registers.
  ctl_e        ctl_phase = CTL_IDLE;
  try_e        try_step  = TRY_SEND;
  logic [3:0]  tries     = '0;
  scan_e       scan      = SCAN_O_OR_R;
  logic [30:0] line_ctr  = '0;
  logic [16:0] silent_ms = '0;
  logic [15:0] limit_ms  = TimeoutReset;
  logic        ok_after  = 1'b1;

  res_t      step_events[$];
  res_t      awaited_events[$];
  plan_row_t plan[$];
  bit        step_acted;
  int        useful_items = 0;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  logic      hold_req = 1'b0;
  logic      no_gaps = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void add_event(event_e kind, logic [30:0] line);
    res_t r;
    r.kind = kind;
    r.line = line;
    r.last = 1'b0;
    step_events.push_back(r);
  endfunction

  function automatic void launch_try();
    if (tries >= MaxTries) begin
      ctl_phase = CTL_IDLE;
      add_event(EV_GAVEUP, '0);
    end else begin
      tries = tries + 4'd1;
      ctl_phase = CTL_WAIT_STATUS;
      if (try_step == TRY_LINE_RESET) begin
        line_ctr = '0;
        add_event(EV_RESET, '0);
      end else begin
        add_event(EV_SEND, line_ctr);
      end
    end
  endfunction

  function automatic void take_retry();
    if (try_step == TRY_SEND) try_step = TRY_RESEND;
    else try_step = TRY_LINE_RESET;
    launch_try();
  endfunction

  function automatic heard_e scan_byte(logic [7:0] c);
    heard_e heard;
    heard = HEARD_NONE;
    case (scan)
      SCAN_O_OR_R: begin
        if (c == CH_LO_O) scan = SCAN_K;
        else if (c == CH_UP_R) scan = SCAN_E1;
      end
      SCAN_K: begin
        scan = SCAN_O_OR_R;
        if (c == CH_LO_K) heard = HEARD_OK;
      end
      SCAN_E1: scan = (c == CH_LO_E) ? SCAN_S : SCAN_O_OR_R;
      SCAN_S:  scan = (c == CH_LO_S) ? SCAN_E2 : SCAN_O_OR_R;
      SCAN_E2: scan = (c == CH_LO_E) ? SCAN_N : SCAN_O_OR_R;
      SCAN_N:  scan = (c == CH_LO_N) ? SCAN_D : SCAN_O_OR_R;
      SCAN_D: begin
        if (c != CH_LO_D) scan = SCAN_O_OR_R;
        else if (ok_after) scan = SCAN_O;
        else heard = HEARD_RESEND;
      end
      SCAN_O: begin
        if (c == CH_LO_O) scan = SCAN_K2;
      end
      SCAN_K2: begin
        if (c == CH_LO_K) heard = HEARD_RESEND;
        else scan = SCAN_O;
      end
      default: scan = SCAN_O_OR_R;
    endcase
    return heard;
  endfunction

  function automatic bit handshake_step(cmd_t c);
    heard_e heard;
    bit     acted;
    res_t   fin;
    step_events.delete();
    acted = 1'b1;
    case (c.op)
      OP_START: begin
        if (ctl_phase != CTL_IDLE) acted = 1'b0;
        else if (c.machine != TargetMachine) add_event(EV_INVALID, '0);
        else if (c.empty) add_event(EV_FAILED, '0);
        else begin
          try_step = TRY_SEND;
          tries = '0;
          launch_try();
        end
      end
      OP_STATUS: begin
        if (ctl_phase != CTL_WAIT_STATUS) acted = 1'b0;
        else if (c.status == ST_OK) begin
          ctl_phase = CTL_WAIT_REPLY;
          scan = SCAN_O_OR_R;
          silent_ms = '0;
        end else begin
          case (c.status)
            ST_ERROR: add_event(EV_TXERR, '0);
            ST_BUSY:  add_event(EV_TXBUSY, '0);
            default:  add_event(EV_TXTIMEOUT, '0);
          endcase
          add_event(EV_FAILED, '0);
          ctl_phase = CTL_IDLE;
        end
      end
      OP_BYTE: begin
        if (ctl_phase != CTL_WAIT_REPLY) acted = 1'b0;
        else begin
          silent_ms = '0;
          heard = scan_byte(c.rx);
          if (heard == HEARD_OK) begin
            line_ctr = line_ctr + 31'd1;
            if (try_step == TRY_LINE_RESET) begin
              try_step = TRY_SEND;
              launch_try();
            end else begin
              ctl_phase = CTL_IDLE;
              add_event(EV_SUCCESS, '0);
            end
          end else if (heard == HEARD_RESEND) begin
            take_retry();
          end
        end
      end
      default: begin
        if (ctl_phase != CTL_WAIT_REPLY) acted = 1'b0;
        else begin
          if (silent_ms != '1) silent_ms = silent_ms + 17'd1;
          if (silent_ms > {1'b0, limit_ms}) begin
            add_event(EV_RXTIMEOUT, '0);
            take_retry();
          end
        end
      end
    endcase
    if (step_events.size() != 0) begin
      fin = step_events.pop_back();
      fin.last = 1'b1;
      step_events.push_back(fin);
    end
    return acted;
  endfunction

  function automatic void plan_add(op_e op, logic [7:0] machine, logic empty,
                                   status_e st, logic [7:0] b, int reps, int n_typed,
                                   event_e k0, logic [30:0] l0, event_e k1);
    plan_row_t row;
    row.cmd.op = op;
    row.cmd.machine = machine;
    row.cmd.empty = empty;
    row.cmd.status = st;
    row.cmd.rx = b;
    row.reps = reps;
    row.n_typed = n_typed;
    row.k0 = k0;
    row.l0 = l0;
    row.k1 = k1;
    plan.push_back(row);
  endfunction

  function automatic cmd_t make_cmd(op_e op);
    cmd_t c;
    c.op = op;
    c.machine = 8'($urandom_range(255));
    c.empty = 1'($urandom_range(1));
    c.status = status_e'($urandom_range(3));
    c.rx = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] other_machine();
    logic [7:0] m;
    m = 8'($urandom_range(255));
    if (m == TargetMachine) m = 8'($urandom_range(255, 2));
    return m;
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(7))
      0: return CH_LO_O;
      1: return CH_LO_K;
      2: return CH_UP_R;
      3: return CH_LO_E;
      4: return CH_LO_S;
      5: return CH_LO_N;
      6: return CH_LO_D;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic offer(cmd_t c);
    if (!no_gaps) begin
      while ($urandom_range(99) < 13) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= c.op;
    in_ch.target_machine <= c.machine;
    in_ch.command_empty <= c.empty;
    in_ch.uart_send_status <= c.status;
    in_ch.rx_byte <= c.rx;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    step_acted = handshake_step(c);
  endtask

  task automatic commit();
    foreach (step_events[i]) awaited_events.push_back(step_events[i]);
    if (step_acted) useful_items++;
  endtask

  task automatic feed(cmd_t c);
    offer(c);
    commit();
  endtask

  task automatic feed_start(logic [7:0] machine, logic empty);
    cmd_t c;
    c = make_cmd(OP_START);
    c.machine = machine;
    c.empty = empty;
    feed(c);
  endtask

  task automatic feed_status(status_e st);
    cmd_t c;
    c = make_cmd(OP_STATUS);
    c.status = st;
    feed(c);
  endtask

  task automatic feed_byte(logic [7:0] b);
    cmd_t c;
    c = make_cmd(OP_BYTE);
    c.rx = b;
    feed(c);
  endtask

  task automatic feed_tick();
    feed(make_cmd(OP_TICK));
  endtask

  task automatic feed_resend_prefix(int upto);
    for (int i = 0; i < upto; i++) begin
      case (i)
        0: feed_byte(CH_UP_R);
        1: feed_byte(CH_LO_E);
        2: feed_byte(CH_LO_S);
        3: feed_byte(CH_LO_E);
        4: feed_byte(CH_LO_N);
        default: feed_byte(CH_LO_D);
      endcase
    end
  endtask

  task automatic reply_round();
    int roll;
    roll = $urandom_range(99);
    repeat ($urandom_range(3)) begin
      if ($urandom_range(1) == 1) feed_byte(pick_char());
      else feed_tick();
    end
    if (roll < 35) begin
      feed_byte(CH_LO_O);
      feed_byte(CH_LO_K);
    end else if (roll < 60) begin
      feed_resend_prefix(6);
      repeat ($urandom_range(2)) feed_byte(pick_char());
      feed_byte(CH_LO_O);
      feed_byte(CH_LO_K);
    end else if (roll < 75) begin
      if (limit_ms <= 16'd50) begin
        while (ctl_phase == CTL_WAIT_REPLY) feed_tick();
      end else begin
        repeat ($urandom_range(5, 1)) feed_tick();
      end
    end else if (roll < 88) begin
      feed_resend_prefix($urandom_range(5, 1));
      feed_byte(8'($urandom_range(255)));
    end else if (roll < 95) begin
      repeat ($urandom_range(4, 1)) feed_byte(8'($urandom_range(255)));
    end else begin
      feed_status(status_e'($urandom_range(3)));
      feed_start(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic random_phase(int quota);
    int target;
    int roll;
    target = useful_items + quota;
    while (useful_items < target) begin
      roll = $urandom_range(99);
      case (ctl_phase)
        CTL_IDLE: begin
          if (roll < 8) feed_start(other_machine(), 1'($urandom_range(1)));
          else if (roll < 14) feed_start(TargetMachine, 1'b1);
          else if (roll < 17) feed_status(status_e'($urandom_range(3)));
          else if (roll < 20) feed_tick();
          else if (roll < 22) feed_byte(pick_char());
          else feed_start(TargetMachine, 1'b0);
        end
        CTL_WAIT_STATUS: begin
          if (roll < 10) feed_status(status_e'($urandom_range(3, 1)));
          else if (roll < 13) feed_start(8'($urandom_range(255)), 1'($urandom_range(1)));
          else if (roll < 16) feed_byte(pick_char());
          else if (roll < 18) feed_tick();
          else feed_status(ST_OK);
        end
        default: reply_round();
      endcase
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_TIMEOUT:  limit_ms = value;
      CFG_OK_AFTER: ok_after = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Result channel: checks each accepted item and drives ready.
  always @(posedge clk_i) begin
    res_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_events.size() == 0) begin
        $error("unexpected item: event_kind %0d, line_number %0d, last_of_run %0d",
               out_ch.event_kind, out_ch.line_number, out_ch.last_of_run);
        mismatches++;
      end else begin
        want = awaited_events.pop_front();
        if (out_ch.event_kind !== want.kind) begin
          $error("event_kind: expected %0d, actual %0d", want.kind, out_ch.event_kind);
          mismatches++;
        end
        if (out_ch.line_number !== want.line) begin
          $error("line_number: expected %0d, actual %0d", want.line, out_ch.line_number);
          mismatches++;
        end
        if (out_ch.last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, actual %0d", want.last, out_ch.last_of_run);
          mismatches++;
        end
      end
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_gaps || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_TICK;
    in_ch.target_machine = '0;
    in_ch.command_empty = 1'b0;
    in_ch.uart_send_status = ST_OK;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_TIMEOUT;
    cfg_ch.data = '0;

    // Directed items under the reset register values.
    plan_add(OP_STATUS, 8'd1, 1'b0, ST_OK, 8'h00, 1, 0, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_BYTE, 8'd1, 1'b0, ST_OK, CH_LO_O, 1, 0, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_TICK, 8'd1, 1'b0, ST_OK, 8'h00, 1, 0, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_START, 8'd0, 1'b0, ST_OK, 8'h00, 1, 1, EV_INVALID, 31'd0, EV_SEND);
    plan_add(OP_START, 8'd255, 1'b1, ST_OK, 8'h00, 1, 1, EV_INVALID, 31'd0, EV_SEND);
    plan_add(OP_START, 8'd1, 1'b1, ST_OK, 8'h00, 1, 1, EV_FAILED, 31'd0, EV_SEND);
    plan_add(OP_START, 8'd1, 1'b0, ST_OK, 8'h00, 1, 1, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_START, 8'd1, 1'b0, ST_OK, 8'h00, 1, 0, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_STATUS, 8'd1, 1'b0, ST_ERROR, 8'h00, 1, 2, EV_TXERR, 31'd0, EV_FAILED);
    plan_add(OP_START, 8'd1, 1'b0, ST_OK, 8'h00, 1, 1, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_STATUS, 8'd1, 1'b0, ST_BUSY, 8'h00, 1, 2, EV_TXBUSY, 31'd0, EV_FAILED);
    plan_add(OP_START, 8'd1, 1'b0, ST_OK, 8'h00, 1, 1, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_STATUS, 8'd1, 1'b0, ST_TIMEOUT, 8'h00, 1, 2, EV_TXTIMEOUT, 31'd0,
             EV_FAILED);
    plan_add(OP_START, 8'd1, 1'b0, ST_OK, 8'h00, 1, 1, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_STATUS, 8'd1, 1'b0, ST_OK, 8'h00, 1, 0, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_TICK, 8'd1, 1'b0, ST_OK, 8'h00, 20, 0, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_STATUS, 8'd1, 1'b0, ST_OK, 8'h00, 1, 0, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_BYTE, 8'd1, 1'b0, ST_OK, CH_LO_O, 1, -1, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_BYTE, 8'd1, 1'b0, ST_OK, CH_LO_K, 1, 1, EV_SUCCESS, 31'd0, EV_SEND);
    plan_add(OP_START, 8'd1, 1'b0, ST_OK, 8'h00, 1, -1, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_STATUS, 8'd1, 1'b0, ST_OK, 8'h00, 1, 0, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_BYTE, 8'd1, 1'b0, ST_OK, 8'hFF, 1, -1, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_BYTE, 8'd1, 1'b0, ST_OK, 8'h00, 1, -1, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_TICK, 8'd1, 1'b0, ST_OK, 8'h00, 1, -1, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_BYTE, 8'd1, 1'b0, ST_OK, CH_LO_O, 1, -1, EV_SEND, 31'd0, EV_SEND);
    plan_add(OP_BYTE, 8'd1, 1'b0, ST_OK, CH_LO_K, 1, -1, EV_SEND, 31'd0, EV_SEND);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        offer(plan[i].cmd);
        if (plan[i].n_typed < 0) begin
          commit();
        end else begin
          if (plan[i].n_typed >= 1) begin
            awaited_events.push_back('{plan[i].k0, plan[i].l0, plan[i].n_typed == 1});
          end
          if (plan[i].n_typed == 2) begin
            awaited_events.push_back('{plan[i].k1, 31'd0, 1'b1});
          end
        end
      end
    end

    drain();
    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_OK_AFTER, 16'd0);

    // The result channel holds off while invalid starts keep arriving.
    hold_req <= 1'b1;
    repeat (16) feed_start(other_machine(), 1'($urandom_range(1)));
    random_phase(150);

    drain();
    write_reg(CFG_TIMEOUT, 16'd3);
    write_reg(CFG_OK_AFTER, 16'd1);
    random_phase(150);

    // Widest timeout: a reply window times out only after 65536 silent ticks.
    drain();
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    random_phase(150);

    drain();
    write_reg(CFG_TIMEOUT, 16'd20);
    write_reg(CFG_OK_AFTER, 16'd0);
    no_gaps <= 1'b1;
    random_phase(150);
    no_gaps <= 1'b0;

    drain();
    write_reg(CFG_TIMEOUT, 16'd2);
    write_reg(CFG_OK_AFTER, 16'd1);
    random_phase(150);

    drain();
    if (mismatches == 0 && awaited_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
